// ===== hdl/dnc_pkg.sv =====
// dnc_pkg: shared types, register codes and constants for the double-normal curve
// evaluator; used by every module in hdl, depends on nothing else
package dnc_pkg;

    localparam int POS_W    = 16;
    localparam int INV_W    = 16;
    localparam int DIFF_W   = 32;
    localparam int DIST_W   = 14;
    localparam int SQ_W     = 2 * DIST_W;
    localparam int FRAC_W   = 24;
    localparam int SHIFT_W  = SQ_W - FRAC_W;
    localparam int TAB_W    = 17;
    localparam int TAB_FRAC = 16;
    localparam int HEIGHT_W = 16;
    localparam int PROD_W   = HEIGHT_W + TAB_W;
    localparam int OUT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PEAK_POSITION       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_INVERSE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INVERSE_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_HEIGHT         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_CUTOFF        = 3'd4;

    localparam logic [POS_W-1:0]    RST_PEAK_POSITION = 16'd0;
    localparam logic [INV_W-1:0]    RST_INVERSE_WIDTH = 16'd256;
    localparam logic [HEIGHT_W-1:0] RST_PEAK_HEIGHT   = 16'd4096;
    localparam logic [POS_W-1:0]    RST_LOWER_CUTOFF  = 16'd0;

    localparam int          SERIES_TERMS = 13;
    localparam logic [63:0] LN2_Q30      = 64'd744261118;
    localparam logic [63:0] ONE_Q30      = 64'd1073741824;
    localparam logic [63:0] ROUND_Q16    = 64'd8192;

    typedef struct packed {
        logic [POS_W-1:0]    peak_position;
        logic [INV_W-1:0]    left_inverse_width;
        logic [INV_W-1:0]    right_inverse_width;
        logic [HEIGHT_W-1:0] peak_height;
        logic [POS_W-1:0]    lower_cutoff;
    } cfg_t;

    typedef struct packed {
        logic               zero;
        logic [SHIFT_W-1:0] shift;
    } tag_t;

    // 2^-f in Q1.16 from t = f*ln2 in Q0.30, series for e^-t
    function automatic logic [TAB_W-1:0] exp2_neg_frac(input logic [63:0] t);
        logic [63:0] term;
        logic [63:0] sum;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = ((term * t) >> 30) / 64'(k);
            if ((k & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return TAB_W'((sum + ROUND_Q16) >> 14);
    endfunction

endpackage

// ===== hdl/double_normal_curve.sv =====
// double_normal_curve: top level of the double-normal selectivity curve evaluator
// holds the configuration registers and the pipeline valid chain;
// depends on dnc_pkg, dnc_front, dnc_square, dnc_frac_rom, dnc_scale
//
//   channel  signals                                   direction
//   input    in_valid, in_ready, position              word in
//   output   out_valid, out_ready, selectivity         word out
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data register write in
//
// seven register stages, one word accepted per cycle while the output is not held;
// the stages hold the two multiplies for the exponent, the index scaling,
// the table read and the height multiply
// rst_n clears the valid chain and loads the register reset values; ready stays low in reset
// each stage holds only while it is full and the stage after it is held, so bubbles
// are filled and an input word is taken while a result waits at the output
module double_normal_curve #(
    parameter int FRACTION_TABLE_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dnc_pkg::POS_W-1:0]         position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dnc_pkg::OUT_W-1:0]         selectivity,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dnc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dnc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(FRACTION_TABLE_DEPTH);
    localparam int NS    = 7;

    dnc_pkg::cfg_t cfg_reg;
    dnc_pkg::cfg_t cfg_next;
    logic          run_reg;
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    logic                       front_zero;
    logic [dnc_pkg::DIST_W-1:0] front_dist;
    dnc_pkg::tag_t              sq_tag;
    logic [IDX_W-1:0]           sq_idx;
    dnc_pkg::tag_t              rom_tag;
    logic [dnc_pkg::TAB_W-1:0]  rom_tab;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dnc_pkg::REG_PEAK_POSITION:       cfg_next.peak_position       = cfg_data;
                dnc_pkg::REG_LEFT_INVERSE_WIDTH:  cfg_next.left_inverse_width  = cfg_data;
                dnc_pkg::REG_RIGHT_INVERSE_WIDTH: cfg_next.right_inverse_width = cfg_data;
                dnc_pkg::REG_PEAK_HEIGHT:         cfg_next.peak_height         = cfg_data;
                dnc_pkg::REG_LOWER_CUTOFF:        cfg_next.lower_cutoff        = cfg_data;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak_position       <= dnc_pkg::RST_PEAK_POSITION;
            cfg_reg.left_inverse_width  <= dnc_pkg::RST_INVERSE_WIDTH;
            cfg_reg.right_inverse_width <= dnc_pkg::RST_INVERSE_WIDTH;
            cfg_reg.peak_height         <= dnc_pkg::RST_PEAK_HEIGHT;
            cfg_reg.lower_cutoff        <= dnc_pkg::RST_LOWER_CUTOFF;
        end
        else
            cfg_reg <= cfg_next;
    end

    // stage enables and valid chain
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready  = en[0] && run_reg;
    assign cfg_ready = run_reg;
    assign out_valid = v_reg[NS-1];

    always_comb
    begin
        v_next = v_reg;
        if (en[0])
            v_next[0] = in_valid && in_ready;
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            v_reg   <= '0;
        end
        else
        begin
            run_reg <= 1'b1;
            v_reg   <= v_next;
        end
    end

    dnc_front u_front (
        .clk      (clk),
        .en       (en[1:0]),
        .cfg      (cfg_reg),
        .position (position),
        .zero     (front_zero),
        .distance (front_dist)
    );

    dnc_square #(
        .DEPTH (FRACTION_TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_square (
        .clk      (clk),
        .en       (en[3:2]),
        .zero_in  (front_zero),
        .distance (front_dist),
        .tag      (sq_tag),
        .idx      (sq_idx)
    );

    dnc_frac_rom #(
        .DEPTH (FRACTION_TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_frac_rom (
        .clk    (clk),
        .en     (en[4]),
        .idx    (sq_idx),
        .tag_in (sq_tag),
        .tab    (rom_tab),
        .tag    (rom_tag)
    );

    dnc_scale u_scale (
        .clk         (clk),
        .en          (en[6:5]),
        .peak_height (cfg_reg.peak_height),
        .tab         (rom_tab),
        .tag         (rom_tag),
        .selectivity (selectivity)
    );

    // pipeline occupancy follows accepted words in and out
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> $countones(v_reg) == $countones($past(v_reg))
            + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready)))
        else $error("pipeline occupancy mismatch");

    // a full pipeline with a held output takes no word
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg) && !out_ready |-> !in_ready)
        else $error("word taken into a full stalled pipeline");

    // an empty output stage lets a word in
    a_open_entry: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && !v_reg[NS-1] |-> in_ready)
        else $error("input held while output stage is empty");

endmodule

// ===== hdl/dnc_front.sv =====
// dnc_front: cutoff test, distance from the peak and scaling by the inverse width
// two register stages; depends on dnc_pkg
module dnc_front (
    input  logic                        clk,
    input  logic [1:0]                  en,
    input  dnc_pkg::cfg_t               cfg,
    input  logic [dnc_pkg::POS_W-1:0]   position,
    output logic                        zero,
    output logic [dnc_pkg::DIST_W-1:0]  distance
);

    logic                        below_next;
    logic                        left_next;
    logic [dnc_pkg::POS_W-1:0]   diff_next;
    logic [dnc_pkg::INV_W-1:0]   inv_next;
    logic [dnc_pkg::DIFF_W-1:0]  scaled_next;

    logic                        zero0_reg;
    logic [dnc_pkg::POS_W-1:0]   diff_reg;
    logic [dnc_pkg::INV_W-1:0]   inv_reg;
    logic                        zero1_reg;
    logic [dnc_pkg::DIST_W-1:0]  dist_reg;

    always_comb
    begin
        below_next = position < cfg.lower_cutoff;
        left_next  = position < cfg.peak_position;
        if (left_next)
        begin
            diff_next = cfg.peak_position - position;
            inv_next  = cfg.left_inverse_width;
        end
        else
        begin
            diff_next = position - cfg.peak_position;
            inv_next  = cfg.right_inverse_width;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            zero0_reg <= below_next;
            diff_reg  <= diff_next;
            inv_reg   <= inv_next;
        end
    end

    assign scaled_next = dnc_pkg::DIFF_W'(diff_reg) * dnc_pkg::DIFF_W'(inv_reg);

    // distance of 2^14 or more squares past the last shift step
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            zero1_reg <= zero0_reg | (|scaled_next[dnc_pkg::DIFF_W-1:dnc_pkg::DIST_W]);
            dist_reg  <= scaled_next[dnc_pkg::DIST_W-1:0];
        end
    end

    assign zero     = zero1_reg;
    assign distance = dist_reg;

endmodule

// ===== hdl/dnc_square.sv =====
// dnc_square: squares the scaled distance and splits it into shift count and table index
// two register stages; depends on dnc_pkg
module dnc_square #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic                        clk,
    input  logic [1:0]                  en,
    input  logic                        zero_in,
    input  logic [dnc_pkg::DIST_W-1:0]  distance,
    output dnc_pkg::tag_t               tag,
    output logic [IDX_W-1:0]            idx
);

    localparam int DEPTH_W = $clog2(DEPTH + 1);
    localparam int SCL_W   = dnc_pkg::FRAC_W + DEPTH_W;

    logic [dnc_pkg::SQ_W-1:0] sq_next;
    logic [SCL_W-1:0]         scl_next;

    logic                     zero_reg;
    logic [dnc_pkg::SQ_W-1:0] sq_reg;
    dnc_pkg::tag_t            tag_reg;
    logic [IDX_W-1:0]         idx_reg;

    assign sq_next = dnc_pkg::SQ_W'(distance) * dnc_pkg::SQ_W'(distance);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            zero_reg <= zero_in;
            sq_reg   <= sq_next;
        end
    end

    assign scl_next = SCL_W'(sq_reg[dnc_pkg::FRAC_W-1:0]) * SCL_W'(DEPTH);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            tag_reg.zero  <= zero_reg;
            tag_reg.shift <= sq_reg[dnc_pkg::SQ_W-1:dnc_pkg::FRAC_W];
            idx_reg       <= scl_next[dnc_pkg::FRAC_W +: IDX_W];
        end
    end

    assign tag = tag_reg;
    assign idx = idx_reg;

endmodule

// ===== hdl/dnc_frac_rom.sv =====
// dnc_frac_rom: constant table of 2^-f for the fraction of the exponent, registered read
// one register stage; depends on dnc_pkg
module dnc_frac_rom #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [IDX_W-1:0]           idx,
    input  dnc_pkg::tag_t              tag_in,
    output logic [dnc_pkg::TAB_W-1:0]  tab,
    output dnc_pkg::tag_t              tag
);

    logic [dnc_pkg::TAB_W-1:0] rom [DEPTH];

    logic [dnc_pkg::TAB_W-1:0] tab_reg;
    dnc_pkg::tag_t             tag_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        localparam logic [63:0] T_ARG = (64'(i) * dnc_pkg::LN2_Q30) / 64'(DEPTH);
        assign rom[i] = dnc_pkg::exp2_neg_frac(T_ARG);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tab_reg <= rom[idx];
            tag_reg <= tag_in;
        end
    end

    assign tab = tab_reg;
    assign tag = tag_reg;

endmodule

// ===== hdl/dnc_scale.sv =====
// dnc_scale: multiplies the peak height by the table value and applies the integer shift
// two register stages, the second one is the output word; depends on dnc_pkg
module dnc_scale (
    input  logic                          clk,
    input  logic [1:0]                    en,
    input  logic [dnc_pkg::HEIGHT_W-1:0]  peak_height,
    input  logic [dnc_pkg::TAB_W-1:0]     tab,
    input  dnc_pkg::tag_t                 tag,
    output logic [dnc_pkg::OUT_W-1:0]     selectivity
);

    logic [dnc_pkg::PROD_W-1:0] prod_next;
    logic [dnc_pkg::OUT_W-1:0]  sel_next;

    logic [dnc_pkg::PROD_W-1:0] prod_reg;
    dnc_pkg::tag_t              tag_reg;
    logic [dnc_pkg::OUT_W-1:0]  sel_reg;

    assign prod_next = dnc_pkg::PROD_W'(peak_height) * dnc_pkg::PROD_W'(tab);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
            tag_reg  <= tag;
        end
    end

    always_comb
    begin
        if (tag_reg.zero)
            sel_next = '0;
        else
            sel_next = dnc_pkg::OUT_W'(prod_reg[dnc_pkg::PROD_W-1:dnc_pkg::TAB_FRAC]
                                       >> tag_reg.shift);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            sel_reg <= sel_next;
    end

    assign selectivity = sel_reg;

endmodule
